// ===== design/gmps_pkg.sv =====
// ============================================================================
// gmps_pkg
// Shared types and codes for the grid maze path search core: the command and
// status bundles between controller and datapath, and the neighbor codes.
// ============================================================================
package gmps_pkg;

    // Width of the side register as written on the configuration port.
    localparam int CFG_W = 7;

    // Neighbor visit order of one popped cell (pushed in reverse of search).
    localparam logic [1:0] NB_LEFT  = 2'd0;
    localparam logic [1:0] NB_UP    = 2'd1;
    localparam logic [1:0] NB_RIGHT = 2'd2;
    localparam logic [1:0] NB_DOWN  = 2'd3;

    // Controller to datapath.
    typedef struct packed {
        logic       cfg_write;  // take new side, restart loading
        logic       ld_write;   // store one loaded cell
        logic       init;       // mark start visited, push start
        logic       pop;        // read top of stack
        logic       nb_issue;   // read cell store at selected neighbor
        logic [1:0] nb_sel;
        logic       out_load;   // load result register
        logic       found;
    } t_cmd;

    // Datapath to controller.
    typedef struct packed {
        logic ld_last;      // load pointer sits on the last cell
        logic stack_empty;
        logic cur_goal;     // popped entry is the bottom-right corner
        logic out_free;     // result register can take a value this cycle
    } t_sts;

endpackage

// ===== design/gmps_ctrl.sv =====
// ============================================================================
// gmps_ctrl
// Sequencer: loading, search init, pop, four neighbor steps, result hand-off.
// ============================================================================
module gmps_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_cfg_valid,
    input  gmps_pkg::t_sts  i_sts,
    output gmps_pkg::t_cmd  o_cmd,
    output logic            o_in_stall,
    output logic            o_cfg_ready
);

    localparam logic [3:0] S_LOAD = 4'd0;
    localparam logic [3:0] S_INIT = 4'd1;
    localparam logic [3:0] S_POP  = 4'd2;
    localparam logic [3:0] S_NB0  = 4'd3;
    localparam logic [3:0] S_NB1  = 4'd4;
    localparam logic [3:0] S_NB2  = 4'd5;
    localparam logic [3:0] S_NB3  = 4'd6;
    localparam logic [3:0] S_NB4  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0] r_state, n_state;
    logic       r_found, n_found;
    logic       in_acc, cfg_acc;

    assign in_acc      = (r_state == S_LOAD) && i_in_valid;
    assign cfg_acc     = (r_state == S_LOAD) && i_cfg_valid;
    // a pending side write holds the cell input off for that cycle
    assign o_in_stall  = (r_state != S_LOAD) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_LOAD);

    always_comb begin
        n_state        = r_state;
        n_found        = r_found;
        o_cmd          = '0;
        o_cmd.found    = r_found;
        o_cmd.cfg_write = cfg_acc;
        unique case (r_state)
            S_LOAD: begin
                // config write wins over a cell in the same cycle
                if (in_acc && !cfg_acc) begin
                    o_cmd.ld_write = 1'b1;
                    if (i_sts.ld_last) begin
                        n_state = S_INIT;
                    end
                end
            end
            S_INIT: begin
                o_cmd.init = 1'b1;
                n_state    = S_POP;
            end
            S_POP: begin
                if (i_sts.stack_empty) begin
                    n_found = 1'b0;
                    n_state = S_DONE;
                end else begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_NB0;
                end
            end
            S_NB0: begin
                if (i_sts.cur_goal) begin
                    n_found = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.nb_issue = 1'b1;
                    o_cmd.nb_sel   = gmps_pkg::NB_LEFT;
                    n_state        = S_NB1;
                end
            end
            S_NB1: begin
                o_cmd.nb_issue = 1'b1;
                o_cmd.nb_sel   = gmps_pkg::NB_UP;
                n_state        = S_NB2;
            end
            S_NB2: begin
                o_cmd.nb_issue = 1'b1;
                o_cmd.nb_sel   = gmps_pkg::NB_RIGHT;
                n_state        = S_NB3;
            end
            S_NB3: begin
                o_cmd.nb_issue = 1'b1;
                o_cmd.nb_sel   = gmps_pkg::NB_DOWN;
                n_state        = S_NB4;
            end
            S_NB4: begin
                // last neighbor evaluates in datapath this cycle
                n_state = S_POP;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_LOAD;
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_found <= n_found;
        end
    end

endmodule

// ===== design/gmps_dp.sv =====
// ============================================================================
// gmps_dp
// Datapath: side register, load pointer, cell store, search stack, neighbor
// read/evaluate pipe and the result register.
// ============================================================================
module gmps_dp #(
    parameter int MAX_SIDE = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gmps_pkg::t_cmd              i_cmd,
    output gmps_pkg::t_sts              o_sts,
    input  logic [gmps_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                        i_cell_free,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic                        o_path_found
);

    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int IW    = $clog2(CELLS);
    localparam int RW    = $clog2(MAX_SIDE);
    localparam int DW    = IW + 1;

    typedef struct packed {
        logic [RW-1:0] row;
        logic [RW-1:0] col;
        logic [IW-1:0] idx;
    } t_entry;

    logic [RW-1:0] r_side_m1, n_side_m1;
    logic [RW-1:0] r_ld_row, r_ld_col;
    logic [IW-1:0] r_ld_idx;
    logic [DW-1:0] r_depth;
    logic [DW-1:0] depth_m1;

    logic          r_cell_mem [CELLS];
    t_entry        r_stack_mem [CELLS];
    logic          r_cell_rd;
    t_entry        r_cur;

    logic          r_nb_valid;
    t_entry        r_nb_entry;
    t_entry        nb_entry;
    logic          nb_ok;
    logic          push;
    logic [IW-1:0] side_iw;
    logic          ld_last;

    logic          r_out_valid, r_path_found;

    // clamp written side to 1..MAX_SIDE, keep side-1
    always_comb begin
        if (i_cfg_data == '0) begin
            n_side_m1 = '0;
        end else if (int'(i_cfg_data) > MAX_SIDE) begin
            n_side_m1 = RW'(MAX_SIDE - 1);
        end else begin
            n_side_m1 = RW'(i_cfg_data - gmps_pkg::CFG_W'(1));
        end
    end

    assign ld_last  = (r_ld_row == r_side_m1) && (r_ld_col == r_side_m1);
    assign side_iw  = IW'(r_side_m1) + IW'(1);
    assign depth_m1 = r_depth - DW'(1);
    assign push     = r_nb_valid && r_cell_rd;

    // neighbor of the popped cell
    always_comb begin
        nb_entry = r_cur;
        nb_ok    = 1'b0;
        unique case (i_cmd.nb_sel)
            gmps_pkg::NB_LEFT: begin
                nb_ok        = (r_cur.col != '0);
                nb_entry.col = r_cur.col - RW'(1);
                nb_entry.idx = r_cur.idx - IW'(1);
            end
            gmps_pkg::NB_UP: begin
                nb_ok        = (r_cur.row != '0);
                nb_entry.row = r_cur.row - RW'(1);
                nb_entry.idx = r_cur.idx - side_iw;
            end
            gmps_pkg::NB_RIGHT: begin
                nb_ok        = (r_cur.col != r_side_m1);
                nb_entry.col = r_cur.col + RW'(1);
                nb_entry.idx = r_cur.idx + IW'(1);
            end
            gmps_pkg::NB_DOWN: begin
                nb_ok        = (r_cur.row != r_side_m1);
                nb_entry.row = r_cur.row + RW'(1);
                nb_entry.idx = r_cur.idx + side_iw;
            end
            default: begin
                nb_ok = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side_m1  <= '0;
            r_ld_row   <= '0;
            r_ld_col   <= '0;
            r_ld_idx   <= '0;
            r_depth    <= '0;
            r_nb_valid <= 1'b0;
        end else begin
            r_nb_valid <= i_cmd.nb_issue && nb_ok;
            priority if (i_cmd.cfg_write) begin
                r_side_m1 <= n_side_m1;
                r_ld_row  <= '0;
                r_ld_col  <= '0;
                r_ld_idx  <= '0;
                r_depth   <= '0;
            end else if (i_cmd.ld_write) begin
                if (ld_last) begin
                    r_ld_row <= '0;
                    r_ld_col <= '0;
                    r_ld_idx <= '0;
                end else if (r_ld_col == r_side_m1) begin
                    r_ld_row <= r_ld_row + RW'(1);
                    r_ld_col <= '0;
                    r_ld_idx <= r_ld_idx + IW'(1);
                end else begin
                    r_ld_col <= r_ld_col + RW'(1);
                    r_ld_idx <= r_ld_idx + IW'(1);
                end
            end else if (i_cmd.init) begin
                r_depth <= DW'(1);
            end else if (i_cmd.pop) begin
                r_depth <= depth_m1;
            end else if (push) begin
                r_depth <= r_depth + DW'(1);
            end
        end
    end

    // cell store: one write, one registered read
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.ld_write) begin
            r_cell_mem[r_ld_idx] <= i_cell_free;
        end else if (i_cmd.init) begin
            r_cell_mem[0] <= 1'b0;
        end else if (push) begin
            r_cell_mem[r_nb_entry.idx] <= 1'b0;
        end
        if (i_cmd.nb_issue) begin
            r_cell_rd <= r_cell_mem[nb_entry.idx];
        end
    end

    // search stack
    always_ff @(posedge i_clk) begin
        priority if (i_cmd.init) begin
            r_stack_mem[0] <= '0;
        end else if (push) begin
            r_stack_mem[r_depth[IW-1:0]] <= r_nb_entry;
        end
        if (i_cmd.pop) begin
            r_cur <= r_stack_mem[depth_m1[IW-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_nb_entry <= nb_entry;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_path_found <= i_cmd.found;
        end
    end

    assign o_sts.ld_last     = ld_last;
    assign o_sts.stack_empty = (r_depth == '0);
    assign o_sts.cur_goal    = (r_cur.row == r_side_m1) && (r_cur.col == r_side_m1);
    assign o_sts.out_free    = !r_out_valid || !i_out_stall;

    assign o_out_valid  = r_out_valid;
    assign o_path_found = r_path_found;

endmodule

// ===== design/grid_maze_path_search_core.sv =====
// ============================================================================
// grid_maze_path_search_core
// Loads a square grid of free/wall cells, then runs a depth-first search from
// the top-left corner and reports whether the bottom-right corner is reached.
// ============================================================================
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+-----------------------
//  in      | in        | i_in_valid / o_in_stall | i_cell_free
//  out     | out       | o_out_valid/i_out_stall | o_path_found
//  cfg     | in        | i_cfg_valid/o_cfg_ready | i_cfg_data (grid side)
//
//  Flow: one cell transfer per cycle while loading, unless a pending side
//  write holds the cell input off. After the last cell the input stalls for
//  the search: an init step, then per popped cell one stack read plus four
//  neighbor reads of the cell store, each evaluated in the cycle after its
//  read, ending at the goal or an empty stack; then the result is loaded.
//  The single read ports of stack and cell store set that per-cell order.
//  Reset: control state only; no clearing pass, cell store and stack hold
//  nothing meaningful until written. Side resets to 1.
//  Stalls: a waiting result holds in the output register; loading and search
//  of the next grid proceed meanwhile, then its answer waits in the sequencer,
//  with the cell input stalled, until the register frees.
//  A config write restarts loading at the top-left cell; a cell offered in
//  the same cycle is stalled and taken afterwards.
// ============================================================================
module grid_maze_path_search_core #(
    parameter int MAX_SIDE = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // cell input
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_cell_free,
    // result output
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic                        o_path_found,
    // side register write
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [gmps_pkg::CFG_W-1:0]  i_cfg_data
);

    gmps_pkg::t_cmd cmd;
    gmps_pkg::t_sts sts;

    // sequencer: phase and step of the search
    gmps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_cfg_ready (o_cfg_ready)
    );

    // storage, pointers and result register
    gmps_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_cfg_data   (i_cfg_data),
        .i_cell_free  (i_cell_free),
        .i_out_stall  (i_out_stall),
        .o_out_valid  (o_out_valid),
        .o_path_found (o_path_found)
    );

endmodule

// ===== design/gmps_chk.sv =====
// ============================================================================
// gmps_chk
// Port-level checks of the grid maze path search core, bound to the top.
// ============================================================================
module gmps_chk (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        i_cell_free,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic                        o_path_found,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready,
    input logic [gmps_pkg::CFG_W-1:0]  i_cfg_data
);

    // a stalled result stays and holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_path_found))
        else $error("result dropped or changed under stall");

    // nothing pending out of reset
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // cells are only taken while side writes are open
    a_cfg_in_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> o_cfg_ready)
        else $error("cell input open outside loading");

    // a new result only appears at the end of a search
    a_rose_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result without preceding search");

endmodule

bind grid_maze_path_search_core gmps_chk u_gmps_chk (.*);

// ===== tb/gmps_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gmps_checker
// Watches the cell, result and side-register channels of the maze search core,
// predicts each reachability answer and compares it with the transferred one.
// ----------------------------------------------------------------------------
module gmps_checker #(
    parameter int MAX_SIDE = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  logic                        i_cell_free,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  logic                        i_path_found,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [gmps_pkg::CFG_W-1:0]  i_cfg_data,
    output int                          o_fail_count,
    output int                          o_pending
);

    localparam int unsigned CELLS = MAX_SIDE * MAX_SIDE;

    logic                        cell_mem [0:CELLS-1];
    logic [gmps_pkg::CFG_W-1:0]  side_reg;
    int unsigned                 load_cnt;
    int unsigned                 side;
    int unsigned                 total;
    logic                        answer_q [$];
    logic                        want;
    int                          fail_cnt = 0;

    function automatic int unsigned side_in_use(input logic [gmps_pkg::CFG_W-1:0] raw);
        if (raw == '0) return 1;
        if (raw > MAX_SIDE) return MAX_SIDE;
        return 32'(raw);
    endfunction

    // Depth-first search from the top-left cell; visited cells are cleared in
    // a private copy of the grid so every cell is pushed at most once.
    function automatic logic corner_reachable(input int unsigned sd);
        logic        open_cell [0:CELLS-1];
        int unsigned pend [$];
        int unsigned idx, r, c, goal, nb;
        logic        ok;
        logic [1:0]  dir;
        open_cell = cell_mem;
        goal = sd * sd - 1;
        open_cell[0] = 1'b0;        // start entered without a wall check
        pend.push_back(0);
        while (pend.size() > 0) begin
            idx = pend.pop_back();
            if (idx == goal) return 1'b1;
            r = idx / sd;
            c = idx % sd;
            // left, up, right, down pushed so that down is explored first
            for (int k = 0; k < 4; k++) begin
                dir = k[1:0];
                ok  = 1'b0;
                nb  = 0;
                case (dir)
                    gmps_pkg::NB_LEFT:  if (c > 0)      begin nb = idx - 1;  ok = 1'b1; end
                    gmps_pkg::NB_UP:    if (r > 0)      begin nb = idx - sd; ok = 1'b1; end
                    gmps_pkg::NB_RIGHT: if (c + 1 < sd) begin nb = idx + 1;  ok = 1'b1; end
                    gmps_pkg::NB_DOWN:  if (r + 1 < sd) begin nb = idx + sd; ok = 1'b1; end
                    default: ;
                endcase
                if (ok && open_cell[nb]) begin
                    open_cell[nb] = 1'b0;
                    pend.push_back(nb);
                end
            end
        end
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            side_reg = gmps_pkg::CFG_W'(1);
            load_cnt = 0;
            answer_q.delete();
        end else begin
            // result side first, so an answer never matches the grid that
            // completes on the same edge
            if (i_out_valid && !i_out_stall) begin
                if (answer_q.size() == 0) begin
                    $error("path_found: unexpected result, expected none, actual %0b",
                           i_path_found);
                    fail_cnt++;
                end else begin
                    want = answer_q.pop_front();
                    if (i_path_found !== want) begin
                        $error("path_found mismatch: expected %0b, actual %0b",
                               want, i_path_found);
                        fail_cnt++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                side_reg = i_cfg_data;
                load_cnt = 0;       // loading restarts at the top-left cell
            end
            if (i_in_valid && !i_in_stall) begin
                side  = side_in_use(side_reg);
                total = side * side;
                if (load_cnt >= total) load_cnt = 0;
                cell_mem[load_cnt] = i_cell_free;
                load_cnt++;
                if (load_cnt == total) begin
                    answer_q.push_back(corner_reachable(side));
                    load_cnt = 0;
                end
            end
        end
        o_pending    <= answer_q.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the grid maze path search core: directed grids,
// extreme sides, mid-grid side rewrites, then random mazes under random stalls.
// ----------------------------------------------------------------------------
module tb;

    // Longest quiet stretch of a correct run is one 12x12 search behind the
    // long receiver hold; the limit is that stretch taken several times over.
    localparam int STUCK_LIMIT = 6000;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 650;
    localparam int QUIET_AFTER = 570;

    logic                        clk;
    logic                        rst_n     = 1'b0;
    logic                        in_valid  = 1'b0;
    logic                        in_stall;
    logic                        cell_free = 1'b0;
    logic                        out_valid;
    logic                        out_stall = 1'b0;
    logic                        path_found;
    logic                        cfg_valid = 1'b0;
    logic                        cfg_ready;
    logic [gmps_pkg::CFG_W-1:0]  cfg_data  = '0;

    int  fail_count;
    int  pending_count;
    int  items_sent = 0;
    int  stuck      = 0;
    bit  quiet      = 1'b0;     // last part of the run: no idling anywhere
    bit  hold_req   = 1'b0;     // asks the receiver for its long hold-off
    bit  hold_on    = 1'b0;     // long hold-off has started
    bit  hold_done  = 1'b0;

    grid_maze_path_search_core u_top (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .o_in_stall   (in_stall),
        .i_cell_free  (cell_free),
        .o_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .o_path_found (path_found),
        .i_cfg_valid  (cfg_valid),
        .o_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data)
    );

    gmps_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_cell_free  (cell_free),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_path_found (path_found),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any transfer on any channel counts as progress.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready)) begin
            stuck <= 0;
        end else if (stuck >= STUCK_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stuck <= stuck + 1;
        end
    end

    // Result receiver: random stall bursts, one long hold-off once the pressure
    // part starts (the core fills up and stalls cell input), none at the end.
    initial begin
        repeat (3) @(posedge clk);
        forever begin
            if (quiet) begin
                out_stall <= 1'b0;
                @(posedge clk);
            end else if (hold_req && !hold_done) begin
                hold_on = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else if ($urandom_range(0, 3) == 0) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end else begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 30)) @(posedge clk);
            end
        end
    end

    // One cell transfer, then maybe an idle burst on the sender side.
    task automatic send_cell(input logic v);
        in_valid  <= 1'b1;
        cell_free <= v;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        items_sent++;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
    endtask

    // n random cells, each free with probability pct percent.
    task automatic send_cells(input int n, input int pct);
        repeat (n) send_cell($urandom_range(0, 99) < pct);
    endtask

    // Directed grid, cell 0 in bit 0.
    task automatic send_bits(input logic [15:0] bits, input int n);
        for (int i = 0; i < n; i++) send_cell(bits[i]);
    endtask

    // Wait until the core is idle: no answer outstanding, plus a margin.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_side(input logic [gmps_pkg::CFG_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic int pick_density();
        case ($urandom_range(0, 3))
            0:       return 50;
            1:       return 70;
            2:       return 85;
            default: return 100;
        endcase
    endfunction

    initial begin
        int unsigned sd, pick, n_grids;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed ----
        // side after reset is 1: a lone cell always answers yes, wall or not
        send_bits(16'b1, 1);
        send_bits(16'b0, 1);
        settle();
        write_side(7'd2);
        send_bits(16'b1110, 4);         // start is a wall: still entered
        send_bits(16'b1001, 4);         // corner walled in
        send_bits(16'b0111, 4);         // corner itself a wall
        settle();
        write_side(7'd0);               // zero side runs as one
        send_bits(16'b0, 1);
        settle();
        write_side(7'd3);
        send_bits(16'b111_100_111, 9);  // right along row 0, down column 2

        // ---- extremes ----
        settle();
        write_side(7'd127);             // clamps to the largest grid
        send_cells(40, 90);             // partial grid, dropped by the rewrite
        settle();
        write_side(7'd64);
        send_cells(40, 70);             // partial grid, dropped by the rewrite
        settle();
        write_side(7'd5);
        send_cells(7, 100);             // partial again, same side rewritten
        settle();
        write_side(7'd5);
        send_cells(25, 85);
        send_cells(25, 100);

        // ---- pressure: receiver holds off while grids keep coming ----
        settle();
        hold_req = 1'b1;
        wait (hold_on);
        write_side(7'd2);
        send_cells(12, 100);

        // ---- random ----
        while (items_sent < ITEM_TARGET) begin
            if (items_sent >= QUIET_AFTER) quiet = 1'b1;
            settle();
            pick = $urandom_range(0, 99);
            if (pick < 3)        sd = 0;
            else if (pick < 60)  sd = $urandom_range(1, 4);
            else if (pick < 90)  sd = $urandom_range(5, 8);
            else                 sd = $urandom_range(9, 12);
            write_side(sd[gmps_pkg::CFG_W-1:0]);
            if (sd == 0) sd = 1;
            n_grids = $urandom_range(1, 4);
            // keep the total close to the item target
            while (n_grids > 1 && items_sent + n_grids * sd * sd > ITEM_TARGET)
                n_grids--;
            repeat (n_grids) send_cells(sd * sd, pick_density());
            // now and then leave a grid unfinished before the next rewrite
            if (sd > 1 && items_sent < ITEM_TARGET && $urandom_range(0, 9) == 0)
                send_cells($urandom_range(1, sd * sd - 1), pick_density());
        end

        // ---- drain ----
        quiet = 1'b1;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        if (fail_count == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/gmps_pkg.sv
design/gmps_ctrl.sv
design/gmps_dp.sv
design/grid_maze_path_search_core.sv
design/gmps_chk.sv
tb/gmps_checker.sv
tb/tb.sv
